FILE: design/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the source character tokenizer
// Token record, lexer modes, token kinds and the character codes that the
// lexer tests for.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int MAX_RES      = 3;

    typedef logic [COUNTER_BITS-1:0] t_count;

    typedef enum logic [7:0] {
        MODE_NORMAL = 8'b0000_0001,
        MODE_OP     = 8'b0000_0010,
        MODE_CBODY  = 8'b0000_0100,
        MODE_CESC   = 8'b0000_1000,
        MODE_CCLOSE = 8'b0001_0000,
        MODE_SBODY  = 8'b0010_0000,
        MODE_SESC   = 8'b0100_0000,
        MODE_ERROR  = 8'b1000_0000
    } t_mode;

    localparam logic [3:0] KIND_LPAREN = 4'd0;
    localparam logic [3:0] KIND_RPAREN = 4'd1;
    localparam logic [3:0] KIND_LBRACE = 4'd2;
    localparam logic [3:0] KIND_RBRACE = 4'd3;
    localparam logic [3:0] KIND_LBRACK = 4'd4;
    localparam logic [3:0] KIND_RBRACK = 4'd5;
    localparam logic [3:0] KIND_ARITH  = 4'd6;
    localparam logic [3:0] KIND_ASSIGN = 4'd7;
    localparam logic [3:0] KIND_LOGIC  = 4'd8;
    localparam logic [3:0] KIND_SPACE  = 4'd9;
    localparam logic [3:0] KIND_APOS   = 4'd10;
    localparam logic [3:0] KIND_TEXT   = 4'd11;
    localparam logic [3:0] KIND_QUOTE  = 4'd12;
    localparam logic [3:0] KIND_ERROR  = 4'd13;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  first_char;
        logic [7:0]  second_char;
        logic        has_second;
        logic [15:0] line;
        logic [15:0] column;
    } t_token;

    typedef t_token [MAX_RES-1:0] t_batch;

    function automatic logic [15:0] clamp16(input t_count v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'd65535) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    function automatic t_token make_tok(
        input logic [3:0] kind,
        input logic [7:0] a,
        input logic [7:0] b,
        input logic       has,
        input t_count     line,
        input t_count     col
    );
        t_token t;
        t.kind        = kind;
        t.first_char  = a;
        t.second_char = has ? b : 8'd0;
        t.has_second  = has;
        t.line        = clamp16(line);
        t.column      = clamp16(col);
        return t;
    endfunction

endpackage

FILE: design/sct_tok_buf.sv
// ----------------------------------------------------------------------------
// sct_tok_buf: result buffer of the tokenizer
// Holds the up to three tokens of one request and hands them out in order,
// one per output transfer, reporting how many are still pending.
// ----------------------------------------------------------------------------
module sct_tok_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sct_pkg::t_batch       i_batch,
    input  logic [1:0]            i_count,
    input  logic                  i_pop,
    output sct_pkg::t_token       o_head,
    output logic [1:0]            o_count
);
    import sct_pkg::*;

    t_batch     r_batch;
    t_batch     n_batch;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        n_batch = r_batch;
        n_count = r_count;
        if (i_load) begin
            n_batch = i_batch;
            n_count = i_count;
        end else if (i_pop) begin
            n_batch[0] = r_batch[1];
            n_batch[1] = r_batch[2];
            n_count    = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_batch <= n_batch;
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = r_batch[0];
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_count == 2'd0 || (r_count == 2'd1 && i_pop)))
        else $error("tok_buf: load while tokens still pending");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0)
        else $error("tok_buf: pop from empty buffer");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_load && i_pop) |=> r_count == $past(r_count) - 2'd1)
        else $error("tok_buf: count did not drop on pop");
`endif

endmodule

FILE: design/source_char_tokenizer.sv
// ----------------------------------------------------------------------------
// source_char_tokenizer: streaming character lexer
// Takes one source byte per request and emits up to three tagged tokens with
// line and column, holding =, !, < and > for one byte of lookahead.
//
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_ready    | i_ch, i_end_of_code
//   out     | output    | o_out_valid / i_out_ready  | o_kind .. o_last_of_run
//
// A request is lexed in the cycle it is accepted; its tokens sit in the
// result buffer and leave one per cycle while the output is ready.
// The next request is taken while the last pending token is being taken.
// Reset (synchronous, active low) empties the buffer and returns to line 1,
// column 1 in normal mode. Output stalls hold the buffer and the input.
// ----------------------------------------------------------------------------
module source_char_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_first_char,
    output logic [7:0]  o_second_char,
    output logic        o_has_second,
    output logic [15:0] o_line,
    output logic [15:0] o_column,
    output logic        o_last_of_run
);
    import sct_pkg::*;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [7:0] r_held_op;
    logic [7:0] n_held_op;
    t_count     r_held_col;
    t_count     n_held_col;
    logic [7:0] r_esc_lead;
    logic [7:0] n_esc_lead;
    t_count     r_line;
    t_count     n_line;
    t_count     r_col;
    t_count     n_col;

    t_batch     batch;
    logic [1:0] tok_count;
    logic       do_normal;
    logic       accept;
    logic       pop;
    t_token     head;
    logic [1:0] buf_count;

    assign pop        = o_out_valid && i_out_ready;
    assign o_in_ready = (buf_count == 2'd0) || (buf_count == 2'd1 && i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_mode     = r_mode;
        n_held_op  = r_held_op;
        n_held_col = r_held_col;
        n_esc_lead = r_esc_lead;
        n_line     = r_line;
        n_col      = r_col;
        batch      = '0;
        tok_count  = 2'd0;
        do_normal  = 1'b0;

        case (r_mode)
            MODE_OP: begin
                n_held_op = 8'd0;
                n_mode    = MODE_NORMAL;
                if (i_ch == CH_EQ) begin
                    batch[tok_count] = make_tok(KIND_LOGIC, r_held_op, i_ch, 1'b1,
                                                r_line, r_held_col);
                    tok_count = tok_count + 2'd1;
                end else begin
                    batch[tok_count] = make_tok(
                        (r_held_op == CH_EQ) ? KIND_ASSIGN : KIND_LOGIC,
                        r_held_op, 8'd0, 1'b0, r_line, r_held_col);
                    tok_count = tok_count + 2'd1;
                    do_normal = 1'b1;
                end
            end
            MODE_CBODY: begin
                if (i_ch == CH_BSLASH) begin
                    n_esc_lead = i_ch;
                    n_held_col = r_col;
                    n_mode     = MODE_CESC;
                end else if (i_ch == CH_APOS) begin
                    batch[tok_count] = make_tok(KIND_ERROR, i_ch, 8'd0, 1'b0, r_line, r_col);
                    tok_count = tok_count + 2'd1;
                    n_mode    = MODE_ERROR;
                end else begin
                    batch[tok_count] = make_tok(KIND_TEXT, i_ch, 8'd0, 1'b0, r_line, r_col);
                    tok_count = tok_count + 2'd1;
                    n_mode    = MODE_CCLOSE;
                end
            end
            MODE_CESC: begin
                batch[tok_count] = make_tok(KIND_TEXT, r_esc_lead, i_ch, 1'b1,
                                            r_line, r_held_col);
                tok_count = tok_count + 2'd1;
                n_mode    = MODE_CCLOSE;
            end
            MODE_CCLOSE: begin
                if (i_ch == CH_APOS) begin
                    batch[tok_count] = make_tok(KIND_APOS, i_ch, 8'd0, 1'b0, r_line, r_col);
                    n_mode = MODE_NORMAL;
                end else begin
                    batch[tok_count] = make_tok(KIND_ERROR, i_ch, 8'd0, 1'b0, r_line, r_col);
                    n_mode = MODE_ERROR;
                end
                tok_count = tok_count + 2'd1;
            end
            MODE_SBODY: begin
                if (i_ch == CH_QUOTE) begin
                    batch[tok_count] = make_tok(KIND_QUOTE, i_ch, 8'd0, 1'b0, r_line, r_col);
                    tok_count = tok_count + 2'd1;
                    n_mode    = MODE_NORMAL;
                end else if (i_ch == CH_BSLASH) begin
                    n_esc_lead = i_ch;
                    n_held_col = r_col;
                    n_mode     = MODE_SESC;
                end else begin
                    batch[tok_count] = make_tok(KIND_TEXT, i_ch, 8'd0, 1'b0, r_line, r_col);
                    tok_count = tok_count + 2'd1;
                end
            end
            MODE_SESC: begin
                batch[tok_count] = make_tok(KIND_TEXT, r_esc_lead, i_ch, 1'b1,
                                            r_line, r_held_col);
                tok_count = tok_count + 2'd1;
                n_mode    = MODE_SBODY;
            end
            MODE_ERROR: begin
                batch[tok_count] = make_tok(KIND_ERROR, i_ch, 8'd0, 1'b0, r_line, r_col);
                tok_count = tok_count + 2'd1;
            end
            default: begin
                n_mode    = MODE_NORMAL;
                do_normal = 1'b1;
            end
        endcase

        if (do_normal) begin
            case (i_ch)
                CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK: begin
                    case (i_ch)
                        CH_LPAREN: batch[tok_count] = make_tok(KIND_LPAREN, i_ch, 8'd0,
                                                               1'b0, r_line, r_col);
                        CH_RPAREN: batch[tok_count] = make_tok(KIND_RPAREN, i_ch, 8'd0,
                                                               1'b0, r_line, r_col);
                        CH_LBRACE: batch[tok_count] = make_tok(KIND_LBRACE, i_ch, 8'd0,
                                                               1'b0, r_line, r_col);
                        CH_RBRACE: batch[tok_count] = make_tok(KIND_RBRACE, i_ch, 8'd0,
                                                               1'b0, r_line, r_col);
                        CH_LBRACK: batch[tok_count] = make_tok(KIND_LBRACK, i_ch, 8'd0,
                                                               1'b0, r_line, r_col);
                        default:   batch[tok_count] = make_tok(KIND_RBRACK, i_ch, 8'd0,
                                                               1'b0, r_line, r_col);
                    endcase
                    tok_count = tok_count + 2'd1;
                end
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: begin
                    batch[tok_count] = make_tok(KIND_ARITH, i_ch, 8'd0, 1'b0, r_line, r_col);
                    tok_count = tok_count + 2'd1;
                end
                CH_EQ, CH_BANG, CH_LT, CH_GT: begin
                    n_held_op  = i_ch;
                    n_held_col = r_col;
                    n_mode     = MODE_OP;
                end
                CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: begin
                    batch[tok_count] = make_tok(KIND_SPACE, i_ch, 8'd0, 1'b0, r_line, r_col);
                    tok_count = tok_count + 2'd1;
                end
                CH_APOS: begin
                    batch[tok_count] = make_tok(KIND_APOS, i_ch, 8'd0, 1'b0, r_line, r_col);
                    tok_count = tok_count + 2'd1;
                    n_mode    = MODE_CBODY;
                end
                CH_QUOTE: begin
                    batch[tok_count] = make_tok(KIND_QUOTE, i_ch, 8'd0, 1'b0, r_line, r_col);
                    tok_count = tok_count + 2'd1;
                    n_mode    = MODE_SBODY;
                end
                default: begin
                end
            endcase
        end

        if (i_end_of_code) begin
            if (n_mode == MODE_OP) begin
                batch[tok_count] = make_tok(
                    (n_held_op == CH_EQ) ? KIND_ASSIGN : KIND_LOGIC,
                    n_held_op, 8'd0, 1'b0, r_line, n_held_col);
                tok_count = tok_count + 2'd1;
                n_mode    = MODE_NORMAL;
            end else if (n_mode != MODE_NORMAL && n_mode != MODE_ERROR) begin
                batch[tok_count] = make_tok(KIND_ERROR, i_ch, 8'd0, 1'b0, r_line, r_col);
                tok_count = tok_count + 2'd1;
                n_mode    = MODE_ERROR;
            end
            n_held_op  = 8'd0;
            n_held_col = t_count'(1);
            n_line     = t_count'(1);
            n_col      = t_count'(1);
        end else if (i_ch == CH_LF) begin
            if (r_line != '1) begin
                n_line = r_line + t_count'(1);
            end
            n_col = t_count'(1);
        end else if (r_col != '1) begin
            n_col = r_col + t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_NORMAL;
            r_held_op  <= 8'd0;
            r_held_col <= t_count'(1);
            r_esc_lead <= 8'd0;
            r_line     <= t_count'(1);
            r_col      <= t_count'(1);
        end else if (accept) begin
            r_mode     <= n_mode;
            r_held_op  <= n_held_op;
            r_held_col <= n_held_col;
            r_esc_lead <= n_esc_lead;
            r_line     <= n_line;
            r_col      <= n_col;
        end
    end

    sct_tok_buf u_tok_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_batch (batch),
        .i_count (tok_count),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (buf_count)
    );

    assign o_out_valid   = buf_count != 2'd0;
    assign o_kind        = head.kind;
    assign o_first_char  = head.first_char;
    assign o_second_char = head.second_char;
    assign o_has_second  = head.has_second;
    assign o_line        = head.line;
    assign o_column      = head.column;
    assign o_last_of_run = buf_count == 2'd1;

`ifndef SYNTHESIS
    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_mode))
        else $error("tokenizer: mode register not one-hot");
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ERROR) |=> (r_mode == MODE_ERROR))
        else $error("tokenizer: left error mode without reset");
    a_eoc_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_code) |=> (r_line == t_count'(1) && r_col == t_count'(1)
                                       && r_held_op == 8'd0))
        else $error("tokenizer: position not rewound after end of code");
`endif

endmodule
